// ----- hdl/nvcs_pkg.sv -----
// ----------------------------------------------------------------------------
// nvcs_pkg: shared types and constants
// widths, codes, controller states and the command/status bundles
// ----------------------------------------------------------------------------
package nvcs_pkg;

	localparam int MAX_LEN   = 64;
	localparam int ADDR_W    = $clog2(MAX_LEN);
	localparam int POS_W     = ADDR_W + 1;
	localparam int ELEM_W    = 16;
	localparam int IDX_W     = 19;
	localparam int SIM_W     = 16;
	localparam int SQSUM_W   = 40;
	localparam int DOT_W     = 48;
	localparam int ROOT_W    = SQSUM_W / 2;
	localparam int REM_W     = ROOT_W + 1;
	localparam int DEN_W     = 2 * ROOT_W;
	localparam int FRAC_W    = 14;
	localparam int MAG_W     = 37;
	localparam int DIVD_W    = MAG_W + FRAC_W;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = DIVD_W;
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 19;

	localparam logic signed [SIM_W-1:0] SIM_START = -16'sd18023;
	localparam logic [FRAC_W:0] SIM_ONE = 15'd16384;
	localparam logic [POS_W-1:0] LEN_RESET = 7'd50;

	localparam logic [1:0] ACT_TARGET = 2'd0;
	localparam logic [1:0] ACT_CAND   = 2'd1;
	localparam logic [1:0] ACT_END    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCL_N = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXCL_0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXCL_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXCL_2 = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_PREP,
		ST_SQRT,
		ST_DEN,
		ST_DIV,
		ST_UPD,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic ready;
		logic mul;
		logic acc;
		logic sqrt_init;
		logic sqrt_step;
		logic den_load;
		logic div_step;
		logic update;
		logic report;
	} cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] in_action;
		logic       cand_done;
		logic       out_free;
	} sts_t;

endpackage

// ----- hdl/nvcs_channels.sv -----
// ----------------------------------------------------------------------------
// nvcs channels
// valid/ready channel interfaces for items, results and register writes
// ----------------------------------------------------------------------------
interface nvcs_item_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic signed [15:0] element;
	modport source(output valid, action, element, input ready);
	modport sink(input valid, action, element, output ready);
endinterface

interface nvcs_result_if;
	logic               valid;
	logic               ready;
	logic [18:0]        best_index;
	logic signed [15:0] best_similarity;
	modport source(output valid, best_index, best_similarity, input ready);
	modport sink(input valid, best_index, best_similarity, output ready);
endinterface

interface nvcs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [18:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/nvcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// nvcs_ctrl: sequencing controller
// steps elements: multiply, accumulate; full candidates: root, divide, update
// ----------------------------------------------------------------------------
module nvcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  nvcs_pkg::sts_t sts,
	output nvcs_pkg::cmd_t cmd
);

	nvcs_pkg::state_t state_q, state_nx;
	logic [nvcs_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nvcs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == state_nx && (state_q == nvcs_pkg::ST_SQRT ||
					state_q == nvcs_pkg::ST_DIV))
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			nvcs_pkg::ST_IDLE: begin
				if (sts.in_valid) begin
					case (sts.in_action)
						nvcs_pkg::ACT_TARGET, nvcs_pkg::ACT_CAND: state_nx = nvcs_pkg::ST_MUL;
						nvcs_pkg::ACT_END: state_nx = nvcs_pkg::ST_REPORT;
						default: state_nx = nvcs_pkg::ST_IDLE;
					endcase
				end
			end
			nvcs_pkg::ST_MUL: state_nx = nvcs_pkg::ST_ACC;
			nvcs_pkg::ST_ACC: state_nx = sts.cand_done ? nvcs_pkg::ST_PREP : nvcs_pkg::ST_IDLE;
			nvcs_pkg::ST_PREP: state_nx = nvcs_pkg::ST_SQRT;
			nvcs_pkg::ST_SQRT: begin
				if (cnt_q == nvcs_pkg::CNT_W'(nvcs_pkg::SQRT_STEPS - 1))
					state_nx = nvcs_pkg::ST_DEN;
			end
			nvcs_pkg::ST_DEN: state_nx = nvcs_pkg::ST_DIV;
			nvcs_pkg::ST_DIV: begin
				if (cnt_q == nvcs_pkg::CNT_W'(nvcs_pkg::DIV_STEPS - 1))
					state_nx = nvcs_pkg::ST_UPD;
			end
			nvcs_pkg::ST_UPD: state_nx = nvcs_pkg::ST_IDLE;
			nvcs_pkg::ST_REPORT: begin
				if (sts.out_free)
					state_nx = nvcs_pkg::ST_IDLE;
			end
			default: state_nx = nvcs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			nvcs_pkg::ST_IDLE:   cmd.ready = 1'b1;
			nvcs_pkg::ST_MUL:    cmd.mul = 1'b1;
			nvcs_pkg::ST_ACC:    cmd.acc = 1'b1;
			nvcs_pkg::ST_PREP:   cmd.sqrt_init = 1'b1;
			nvcs_pkg::ST_SQRT:   cmd.sqrt_step = 1'b1;
			nvcs_pkg::ST_DEN:    cmd.den_load = 1'b1;
			nvcs_pkg::ST_DIV:    cmd.div_step = 1'b1;
			nvcs_pkg::ST_UPD:    cmd.update = 1'b1;
			nvcs_pkg::ST_REPORT: cmd.report = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- hdl/nvcs_datapath.sv -----
// ----------------------------------------------------------------------------
// nvcs_datapath: target store, accumulators, root and divide units
// holds registers, best-so-far tracking and the result register
// ----------------------------------------------------------------------------
module nvcs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  nvcs_pkg::cmd_t    cmd,
	output nvcs_pkg::sts_t    sts,
	nvcs_item_if.sink         items,
	nvcs_result_if.source     results,
	nvcs_cfg_if.sink          cfg
);

	// configuration
	logic [nvcs_pkg::POS_W-1:0] vlen_q;
	logic [1:0]                 excl_n_q;
	logic [nvcs_pkg::IDX_W-1:0] excl0_q, excl1_q, excl2_q;

	// item and store
	logic [1:0]                        act_q;
	logic signed [nvcs_pkg::ELEM_W-1:0] elem_q, rd_q;
	logic signed [nvcs_pkg::ELEM_W-1:0] store_q [nvcs_pkg::MAX_LEN];
	logic signed [2*nvcs_pkg::ELEM_W-1:0] sq_s1, pr_s1;

	// scan state
	logic [nvcs_pkg::POS_W-1:0]   tpos_q, cpos_q;
	logic [nvcs_pkg::SQSUM_W-1:0] tsum_q, csum_q;
	logic signed [nvcs_pkg::DOT_W-1:0] dot_q;
	logic [nvcs_pkg::IDX_W-1:0]   ccnt_q, bidx_q;
	logic signed [nvcs_pkg::SIM_W-1:0] bsim_q;

	// root and divide
	logic [nvcs_pkg::SQSUM_W-1:0] rad_t_q, rad_c_q;
	logic [nvcs_pkg::REM_W-1:0]   rem_t_q, rem_c_q;
	logic [nvcs_pkg::ROOT_W-1:0]  root_t_q, root_c_q;
	logic [nvcs_pkg::DEN_W-1:0]   den_q, drem_q;
	logic [nvcs_pkg::DIVD_W-1:0]  divd_q, quo_q;
	logic                         neg_q, zero_q;

	// result register
	logic                              out_valid_q;
	logic [nvcs_pkg::IDX_W-1:0]        out_idx_q;
	logic signed [nvcs_pkg::SIM_W-1:0] out_sim_q;

	logic [nvcs_pkg::POS_W-1:0] len_eff, tpos_base, cpos_nx;
	logic                       tpos_wrap, take;
	logic [nvcs_pkg::DOT_W-1:0] dot_mag;
	logic [nvcs_pkg::DEN_W:0]   dtrial;
	logic [nvcs_pkg::FRAC_W:0]  mag_sat;
	logic signed [nvcs_pkg::SIM_W:0] sim;
	logic                       excluded;
	logic [nvcs_pkg::REM_W+1:0] rt_trial, rc_trial, rt_shift, rc_shift;

	assign take = cmd.ready && items.valid;
	assign items.ready = cmd.ready;
	assign cfg.ready = 1'b1;

	assign len_eff = (vlen_q == '0) ? nvcs_pkg::POS_W'(1) :
		(vlen_q > nvcs_pkg::POS_W'(nvcs_pkg::MAX_LEN)) ? nvcs_pkg::POS_W'(nvcs_pkg::MAX_LEN) : vlen_q;
	assign tpos_wrap = tpos_q >= len_eff;
	assign tpos_base = tpos_wrap ? '0 : tpos_q;
	assign cpos_nx   = cpos_q + 1'b1;

	assign sts.in_valid  = items.valid;
	assign sts.in_action = items.action;
	assign sts.cand_done = (act_q == nvcs_pkg::ACT_CAND) && (cpos_nx >= len_eff);
	assign sts.out_free  = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q   <= nvcs_pkg::LEN_RESET;
			excl_n_q <= '0;
			excl0_q  <= '0;
			excl1_q  <= '0;
			excl2_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				nvcs_pkg::REG_LENGTH: vlen_q   <= cfg.data[nvcs_pkg::POS_W-1:0];
				nvcs_pkg::REG_EXCL_N: excl_n_q <= cfg.data[1:0];
				nvcs_pkg::REG_EXCL_0: excl0_q  <= cfg.data;
				nvcs_pkg::REG_EXCL_1: excl1_q  <= cfg.data;
				nvcs_pkg::REG_EXCL_2: excl2_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// target memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.mul && act_q == nvcs_pkg::ACT_TARGET)
			store_q[tpos_base[nvcs_pkg::ADDR_W-1:0]] <= elem_q;
		if (take)
			rd_q <= store_q[cpos_q[nvcs_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_q  <= items.action;
			elem_q <= items.element;
		end
		if (cmd.mul) begin
			sq_s1 <= elem_q * elem_q;
			pr_s1 <= elem_q * rd_q;
		end
	end

	// one restoring root step on both radicands
	assign rt_shift = {rem_t_q, rad_t_q[nvcs_pkg::SQSUM_W-1 -: 2]};
	assign rc_shift = {rem_c_q, rad_c_q[nvcs_pkg::SQSUM_W-1 -: 2]};
	assign rt_trial = {1'b0, root_t_q, 2'b01};
	assign rc_trial = {1'b0, root_c_q, 2'b01};

	assign dot_mag = dot_q[nvcs_pkg::DOT_W-1] ? nvcs_pkg::DOT_W'(-dot_q) : dot_q;
	assign dtrial  = {drem_q, divd_q[nvcs_pkg::DIVD_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			rad_t_q  <= tsum_q;
			rad_c_q  <= csum_q;
			rem_t_q  <= '0;
			rem_c_q  <= '0;
			root_t_q <= '0;
			root_c_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_t_q <= rad_t_q << 2;
			rad_c_q <= rad_c_q << 2;
			if (rt_shift >= rt_trial) begin
				rem_t_q  <= nvcs_pkg::REM_W'(rt_shift - rt_trial);
				root_t_q <= {root_t_q[nvcs_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_t_q  <= rt_shift[nvcs_pkg::REM_W-1:0];
				root_t_q <= {root_t_q[nvcs_pkg::ROOT_W-2:0], 1'b0};
			end
			if (rc_shift >= rc_trial) begin
				rem_c_q  <= nvcs_pkg::REM_W'(rc_shift - rc_trial);
				root_c_q <= {root_c_q[nvcs_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_c_q  <= rc_shift[nvcs_pkg::REM_W-1:0];
				root_c_q <= {root_c_q[nvcs_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.den_load) begin
			den_q  <= root_t_q * root_c_q;
			zero_q <= (root_t_q == '0) || (root_c_q == '0);
			neg_q  <= dot_q[nvcs_pkg::DOT_W-1];
			divd_q <= {dot_mag[nvcs_pkg::MAG_W-1:0], nvcs_pkg::FRAC_W'(0)};
			drem_q <= '0;
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			divd_q <= divd_q << 1;
			if (dtrial >= {1'b0, den_q}) begin
				drem_q <= nvcs_pkg::DEN_W'(dtrial - {1'b0, den_q});
				quo_q  <= {quo_q[nvcs_pkg::DIVD_W-2:0], 1'b1};
			end else begin
				drem_q <= dtrial[nvcs_pkg::DEN_W-1:0];
				quo_q  <= {quo_q[nvcs_pkg::DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign mag_sat = (quo_q > nvcs_pkg::DIVD_W'(nvcs_pkg::SIM_ONE)) ? nvcs_pkg::SIM_ONE :
		quo_q[nvcs_pkg::FRAC_W:0];
	assign sim = neg_q ? -$signed({2'b00, mag_sat}) : $signed({2'b00, mag_sat});
	assign excluded = (excl_n_q >= 2'd1 && ccnt_q == excl0_q) ||
		(excl_n_q >= 2'd2 && ccnt_q == excl1_q) ||
		(excl_n_q == 2'd3 && ccnt_q == excl2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpos_q <= '0;
			tsum_q <= '0;
			cpos_q <= '0;
			csum_q <= '0;
			dot_q  <= '0;
			ccnt_q <= '0;
			bidx_q <= '0;
			bsim_q <= nvcs_pkg::SIM_START;
		end else begin
			if (cmd.acc && act_q == nvcs_pkg::ACT_TARGET) begin
				tpos_q <= tpos_base + 1'b1;
				tsum_q <= (tpos_wrap ? '0 : tsum_q) + nvcs_pkg::SQSUM_W'(unsigned'(sq_s1));
			end
			if (cmd.acc && act_q == nvcs_pkg::ACT_CAND) begin
				cpos_q <= cpos_nx;
				csum_q <= csum_q + nvcs_pkg::SQSUM_W'(unsigned'(sq_s1));
				dot_q  <= dot_q + nvcs_pkg::DOT_W'(pr_s1);
			end
			if (cmd.update) begin
				if (!zero_q && sim > $signed({bsim_q[nvcs_pkg::SIM_W-1], bsim_q}) && !excluded) begin
					bsim_q <= sim[nvcs_pkg::SIM_W-1:0];
					bidx_q <= ccnt_q;
				end
				ccnt_q <= ccnt_q + 1'b1;
			end
			if (cmd.update || cmd.report) begin
				cpos_q <= '0;
				csum_q <= '0;
				dot_q  <= '0;
			end
			if (cmd.report) begin
				ccnt_q <= '0;
				bidx_q <= '0;
				bsim_q <= nvcs_pkg::SIM_START;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.report)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			out_idx_q <= bidx_q;
			out_sim_q <= bsim_q;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.best_index      = out_idx_q;
	assign results.best_similarity = out_sim_q;

endmodule

// ----- hdl/nearest_vector_cosine_search_core.sv -----
// ----------------------------------------------------------------------------
// nearest_vector_cosine_search_core: cosine nearest-vector search
// finds the stored-order candidate most similar to a loaded target vector
// ----------------------------------------------------------------------------
// usage
//  items: action 0 loads the next target element, action 1 streams the next
//   candidate element (paired with the target element at the same position),
//   action 2 ends the scan and produces one transfer on results
//  results: best_index and best_similarity (q1.14), cleared scan afterwards
//  cfg: register writes, always ready; write only while the block is idle
// timing
//  one item at a time; target and mid-vector candidate items are only
//  multiplied and accumulated; a candidate's last element then goes through
//  bit-pair square root (20 steps), restoring divider (51 steps) and update
//  an end item goes via the report state to the result register once it is free
// reset
//  arst_n clears the scan, best so far and result valid, resets length to 50
//  and exclusions to zero; target memory stays undefined until loaded
// stalls
//  a waiting result holds in its register; further items are accepted, only a
//  second end item waits until the first result transfer
// ----------------------------------------------------------------------------
module nearest_vector_cosine_search_core (
	input  logic          clk,
	input  logic          arst_n,
	nvcs_item_if.sink     items,
	nvcs_result_if.source results,
	nvcs_cfg_if.sink      cfg
);

	// command and status between controller and datapath
	nvcs_pkg::cmd_t cmd;
	nvcs_pkg::sts_t sts;

	nvcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	nvcs_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.items   (items),
		.results (results),
		.cfg     (cfg)
	);

endmodule

// ----- sim/nvcs_test_channels.sv -----
// ----------------------------------------------------------------------------
// nvcs test helpers
// nothing beyond the block's own channel interfaces is needed here
// ----------------------------------------------------------------------------
package nvcs_test_pkg;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] element;
	} scan_item_t;

	typedef struct packed {
		logic [18:0]        best_index;
		logic signed [15:0] best_similarity;
	} scan_report_t;

endpackage

// ----- sim/nearest_vector_cosine_search_core_test.sv -----
// ----------------------------------------------------------------------------
// nearest_vector_cosine_search_core_test: self-checking scan testbench
// loads targets, streams candidate vectors and end items with random gaps and
// result stalls, predicts each report and compares it field by field
// ----------------------------------------------------------------------------
module nearest_vector_cosine_search_core_test;

	localparam int MAX_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	logic clk;
	logic arst_n;

	nvcs_item_if   items();
	nvcs_result_if results();
	nvcs_cfg_if    cfg();

	nearest_vector_cosine_search_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items.sink),
		.results(results.source),
		.cfg(cfg.sink)
	);

	// predictor state
	logic signed [15:0] tgt_mem [nvcs_pkg::MAX_LEN];
	int unsigned        tgt_pos;
	logic [63:0]        tgt_sq;
	int unsigned        cand_pos;
	logic signed [63:0] dot_acc;
	logic [63:0]        cand_sq;
	int unsigned        cand_count;
	int unsigned        best_idx;
	int                 best_sim;
	int unsigned        len_reg;
	int unsigned        excl_n;
	int unsigned        excl [3];

	nvcs_test_pkg::scan_item_t   pending_items [$];
	nvcs_test_pkg::scan_report_t expected_reports [$];

	int  mismatch_count;
	int  report_count;
	int  item_count;
	longint cycle;
	bit  gaps_on;
	bit  item_taken;
	int  hold_cycles;

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle, what);
		mismatch_count++;
	endtask

	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic int unsigned active_length();
		if (len_reg < 1) return 1;
		if (len_reg > nvcs_pkg::MAX_LEN) return nvcs_pkg::MAX_LEN;
		return len_reg;
	endfunction

	function automatic bit index_excluded(input int unsigned idx);
		for (int k = 0; k < 3; k++)
			if (excl_n > k && idx == excl[k]) return 1;
		return 0;
	endfunction

	// score one finished candidate against the running best
	task automatic score_candidate();
		logic [63:0] nt;
		logic [63:0] nc;
		longint      sim;
		nt = floor_root(tgt_sq);
		nc = floor_root(cand_sq);
		if (nt != 0 && nc != 0) begin
			sim = (dot_acc * 16384) / $signed(nt * nc);
			if (sim > 16384) sim = 16384;
			if (sim < -16384) sim = -16384;
			if (int'(sim) > best_sim && !index_excluded(cand_count)) begin
				best_sim = int'(sim);
				best_idx = cand_count;
			end
		end
		cand_count = (cand_count + 1) % 524288;
		cand_pos = 0;
		dot_acc = 0;
		cand_sq = 0;
	endtask

	task automatic predict_item(input nvcs_test_pkg::scan_item_t it);
		int unsigned n;
		logic signed [63:0] e;
		nvcs_test_pkg::scan_report_t r;
		n = active_length();
		e = it.element;
		case (it.action)
			nvcs_pkg::ACT_TARGET: begin
				if (tgt_pos >= n) begin
					tgt_pos = 0;
					tgt_sq = 0;
				end
				if (tgt_pos < nvcs_pkg::MAX_LEN) tgt_mem[tgt_pos] = it.element;
				tgt_sq += e * e;
				tgt_pos++;
			end
			nvcs_pkg::ACT_CAND: begin
				if (cand_pos < nvcs_pkg::MAX_LEN) dot_acc += e * tgt_mem[cand_pos];
				cand_sq += e * e;
				cand_pos++;
				if (cand_pos >= n) score_candidate();
			end
			nvcs_pkg::ACT_END: begin
				r.best_index = best_idx[18:0];
				r.best_similarity = best_sim[15:0];
				expected_reports.insert(expected_reports.size(), r);
				cand_pos = 0;
				dot_acc = 0;
				cand_sq = 0;
				cand_count = 0;
				best_idx = 0;
				best_sim = nvcs_pkg::SIM_START;
			end
			default: begin
			end
		endcase
	endtask

	// sampled flag from the rising edge so acceptance is seen once
	always @(posedge clk) begin
		item_taken = arst_n && items.valid && items.ready;
		if (item_taken) begin
			predict_item('{items.action, items.element});
			item_count++;
		end
	end

	// item driver: one valid per item, lowered only when the queue runs dry or
	// a random gap is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!items.valid || item_taken) begin
				if (pending_items.size() > 0 && !(gaps_on && $urandom_range(99) < 14)) begin
					nvcs_test_pkg::scan_item_t it;
					it = pending_items.pop_front();
					items.valid <= 1'b1;
					items.action <= it.action;
					items.element <= it.element;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, held off for a counted stretch when requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= !(gaps_on && $urandom_range(99) < 14);
		end
	end

	// result monitor
	always @(posedge clk) begin
		cycle++;
		if (cycle > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycle);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n && results.valid && results.ready) begin
			report_count++;
			if (expected_reports.size() == 0) begin
				report_mismatch("report with nothing expected");
			end else begin
				nvcs_test_pkg::scan_report_t x;
				x = expected_reports.pop_front();
				if (results.best_index !== x.best_index)
					report_mismatch($sformatf("best_index %0d, predicted %0d",
						results.best_index, x.best_index));
				if (results.best_similarity !== x.best_similarity)
					report_mismatch($sformatf("best_similarity %0d, predicted %0d",
						results.best_similarity, x.best_similarity));
			end
		end
	end

	// wait until every queued item has transferred and all reports are back
	task automatic drain();
		while (pending_items.size() > 0 || items.valid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [nvcs_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val[18:0];
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			nvcs_pkg::REG_LENGTH: len_reg = val & 32'h7f;
			nvcs_pkg::REG_EXCL_N: excl_n = val & 32'h3;
			nvcs_pkg::REG_EXCL_0: excl[0] = val & 32'h7ffff;
			nvcs_pkg::REG_EXCL_1: excl[1] = val & 32'h7ffff;
			default:              excl[2] = val & 32'h7ffff;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_element();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sd0;
			3: return $signed(16'($urandom_range(8191)) - 16'sd4096);
			default: return $signed(16'($urandom));
		endcase
	endfunction

	task automatic queue_item(input logic [1:0] a, input logic signed [15:0] e);
		nvcs_test_pkg::scan_item_t it;
		it.action = a;
		it.element = e;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic queue_target(input int unsigned n);
		for (int k = 0; k < n; k++) queue_item(nvcs_pkg::ACT_TARGET, rand_element());
	endtask

	// a scan: candidates (some all zero), rare spare and partial items, an end item
	task automatic queue_scan(input int unsigned n, input int unsigned cands);
		for (int c = 0; c < cands; c++) begin
			int kind;
			kind = $urandom_range(9);
			for (int k = 0; k < n; k++)
				queue_item(nvcs_pkg::ACT_CAND, kind == 0 ? 16'sd0 : rand_element());
			if ($urandom_range(29) == 0) queue_item(ACT_SPARE, rand_element());
		end
		if ($urandom_range(7) == 0)
			for (int k = 0; k < $urandom_range(n - 1); k++)
				queue_item(nvcs_pkg::ACT_CAND, rand_element());
		queue_item(nvcs_pkg::ACT_END, rand_element());
	endtask

	// budget counts target, whole-candidate and end items of the phase
	task automatic random_phase(input int unsigned n, input int unsigned budget);
		int unsigned used;
		int unsigned cands;
		int unsigned room;
		used = n;
		queue_target(n);
		while (used + n + 1 <= budget) begin
			if ($urandom_range(5) == 0 && used + 2 * n + 1 <= budget) begin
				queue_target(n);
				used += n;
			end
			room = (budget - used - 1) / n;
			cands = $urandom_range(6, 1);
			if (cands > room) cands = room;
			queue_scan(n, cands);
			used += n * cands + 1;
		end
		drain();
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		items.valid = 0;
		items.action = nvcs_pkg::ACT_TARGET;
		items.element = 0;
		results.ready = 0;
		cfg.valid = 0;
		cfg.index = nvcs_pkg::REG_LENGTH;
		cfg.data = 0;
		for (int k = 0; k < nvcs_pkg::MAX_LEN; k++) tgt_mem[k] = 0;
		tgt_pos = 0; tgt_sq = 0; cand_pos = 0; dot_acc = 0; cand_sq = 0;
		cand_count = 0; best_idx = 0; best_sim = nvcs_pkg::SIM_START;
		len_reg = 50; excl_n = 0; excl = '{0, 0, 0};
		mismatch_count = 0; report_count = 0; item_count = 0; cycle = 0;
		gaps_on = 0; hold_cycles = 0; item_taken = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: end before anything, reset length, short vectors
		queue_item(nvcs_pkg::ACT_END, 16'sd0);
		queue_item(ACT_SPARE, 16'sh7fff);
		drain();
		write_reg(nvcs_pkg::REG_LENGTH, 2);
		queue_item(nvcs_pkg::ACT_TARGET, 16'sh7fff);
		queue_item(nvcs_pkg::ACT_TARGET, 16'sh8000);
		queue_item(nvcs_pkg::ACT_CAND, 16'sh7fff);   // parallel
		queue_item(nvcs_pkg::ACT_CAND, 16'sh8000);
		queue_item(nvcs_pkg::ACT_CAND, 16'sh8000);   // opposite
		queue_item(nvcs_pkg::ACT_CAND, 16'sh7fff);
		queue_item(nvcs_pkg::ACT_CAND, 16'sd0);      // zero norm
		queue_item(nvcs_pkg::ACT_CAND, 16'sd0);
		queue_item(nvcs_pkg::ACT_CAND, 16'sh7fff);   // tie with the first, first wins
		queue_item(nvcs_pkg::ACT_CAND, 16'sh8000);
		queue_item(nvcs_pkg::ACT_CAND, 16'sd5);      // partly received, dropped by end
		queue_item(nvcs_pkg::ACT_END, 16'sd0);
		// target overrun starts a new target
		queue_item(nvcs_pkg::ACT_TARGET, 16'sd4096);
		queue_item(nvcs_pkg::ACT_TARGET, 16'sd0);
		queue_item(nvcs_pkg::ACT_TARGET, 16'sd1);
		queue_item(nvcs_pkg::ACT_TARGET, -16'sd4096);
		queue_item(nvcs_pkg::ACT_CAND, 16'sd1);
		queue_item(nvcs_pkg::ACT_CAND, -16'sd1);
		queue_item(nvcs_pkg::ACT_END, 16'sd0);
		drain();

		// exclusions, including all three active and the zero index
		write_reg(nvcs_pkg::REG_EXCL_N, 3);
		write_reg(nvcs_pkg::REG_EXCL_0, 0);
		write_reg(nvcs_pkg::REG_EXCL_1, 2);
		write_reg(nvcs_pkg::REG_EXCL_2, 524287);
		gaps_on = 1;
		random_phase(2, 140);

		// length one, the longest, and clamped lengths with fewer exclusions
		write_reg(nvcs_pkg::REG_EXCL_N, 1);
		write_reg(nvcs_pkg::REG_EXCL_0, 1);
		write_reg(nvcs_pkg::REG_LENGTH, 1);
		random_phase(1, 100);
		write_reg(nvcs_pkg::REG_LENGTH, 64);
		write_reg(nvcs_pkg::REG_EXCL_N, 0);
		gaps_on = 0;   // no gaps while this long vector streams
		random_phase(64, 200);
		gaps_on = 1;
		write_reg(nvcs_pkg::REG_LENGTH, 0);          // clamps to one
		random_phase(1, 50);
		write_reg(nvcs_pkg::REG_LENGTH, 127);        // clamps to the maximum
		write_reg(nvcs_pkg::REG_EXCL_N, 2);
		write_reg(nvcs_pkg::REG_EXCL_1, 3);
		random_phase(64, 140);

		// back pressure: receiver stalls while items keep coming
		write_reg(nvcs_pkg::REG_LENGTH, 3);
		hold_cycles = 3000;
		random_phase(3, 100);
		write_reg(nvcs_pkg::REG_LENGTH, 5);
		random_phase(5, 110);

		$display("%0d items sent, %0d reports checked over lengths 1 to 64",
			item_count, report_count);
		$display("%0d mismatches, exclusions and stalls exercised", mismatch_count);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/nvcs_pkg.sv
hdl/nvcs_channels.sv
hdl/nvcs_ctrl.sv
hdl/nvcs_datapath.sv
hdl/nearest_vector_cosine_search_core.sv
sim/nvcs_test_channels.sv
sim/nearest_vector_cosine_search_core_test.sv
